>>> design/ising_metropolis_spin_update_defines.svh
// assertion macros for the ising metropolis spin update block
// expects aclk and aresetn in the scope of each use
`ifndef ISING_METROPOLIS_SPIN_UPDATE_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IMSU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imsu same-cycle check failed");

// next-cycle implication, checked outside reset
`define IMSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imsu next-cycle check failed");

`endif

>>> design/imsu_pkg.sv
// shared types and constants of the ising metropolis spin update block
// used by imsu_ctrl, imsu_datapath and the top level
package imsu_pkg;

    localparam int SITE_W     = 6;
    localparam int PROB_BITS  = 16;
    localparam int MAG_W      = 14;
    localparam int BOND_W     = 15;
    localparam int CFG_IDX_W  = 3;

    // input tdata layout
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + SITE_W;
    localparam int SPIN_BIT   = COL_LSB + SITE_W;
    localparam int DRAW_LSB   = SPIN_BIT + 1;
    localparam int IN_USED_W  = DRAW_LSB + PROB_BITS;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_USED_W = 2 + MAG_W + BOND_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // opcodes carried on s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // threshold register indexes, also the threshold select codes
    localparam logic [CFG_IDX_W-1:0] REG_ACC_NEG4 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_NEG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_ZERO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_POS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_POS4 = 3'd4;
    localparam int NUM_THR = 5;

    localparam logic [PROB_BITS-1:0] THR_ONE  = '1;
    localparam logic [PROB_BITS-1:0] THR_NONE = '0;

    typedef struct packed {
        logic accept;
        logic read_dn;
        logic exec;
    } imsu_cmd_t;

    typedef struct packed {
        logic out_free;
    } imsu_stat_t;

endpackage

>>> design/ising_metropolis_spin_update.sv
// Metropolis spin update engine for a SIDE x SIDE Ising lattice with periodic wrap.
// Input stream: one item per transfer; s_tuser selects spin write or Metropolis trial.
// Each item gives exactly one result transfer on the m_ side with the site's new spin,
// a flip flag and the running magnetization and bond sums.
// Thresholds are set through cfg_wr_en / cfg_wr_index / cfg_wr_data while idle;
// indexes above four are ignored.
// Each item steps through accept, fetch and execute before the next is accepted;
// execute loads the result register. Up and centre rows are read from the row-wide
// lattice memory at accept, the down row at fetch, over its two read ports before the write.
// The next item is taken while a result still waits in the output register; a
// stalled receiver holds the block in its execute step until the register frees.
// Reset (aresetn low, synchronous): all spins up through per-row valid bits, no
// clearing pass; totals to SIDE*SIDE and 2*SIDE*SIDE, thresholds to their defaults.
// Depends on imsu_pkg, imsu_ctrl, imsu_datapath and the defines header.
`include "ising_metropolis_spin_update_defines.svh"

module ising_metropolis_spin_update #(
    parameter int SIDE = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [imsu_pkg::PROB_BITS-1:0]      cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // site_row, site_col, spin_value, random_draw, zero pad
    input  logic [imsu_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_spin, flipped, magnetization, bond_sum, zero pad
    output logic [imsu_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import imsu_pkg::*;

    imsu_cmd_t  cmd;
    imsu_stat_t stat;

    imsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imsu_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

    `IMSU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `IMSU_ASSERT_NEXT(a_fetch_after_accept, cmd.accept, cmd.read_dn)
    `IMSU_ASSERT_SAME(a_exec_needs_room, cmd.exec, !m_tvalid || m_tready)
    `IMSU_ASSERT_NEXT(a_result_after_exec, cmd.exec, m_tvalid)

endmodule

>>> design/imsu_ctrl.sv
// sequencer of the spin update block: accept, fetch lower row, execute
// depends on imsu_pkg for the command and status structs
module imsu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  imsu_pkg::imsu_stat_t stat,
    output imsu_pkg::imsu_cmd_t  cmd
);
    import imsu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EXEC  = 3'b100
    } imsu_state_t;

    imsu_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.read_dn = 1'b1;
                state_next  = ST_EXEC;
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> design/imsu_datapath.sv
// lattice row memory, neighbor sum, acceptance test, running totals, output register
// depends on imsu_pkg; driven by imsu_ctrl commands
module imsu_datapath #(
    parameter int SIDE = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  imsu_pkg::imsu_cmd_t                 cmd,
    output imsu_pkg::imsu_stat_t                stat,
    input  logic                                cfg_wr_en,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [imsu_pkg::PROB_BITS-1:0]      cfg_wr_data,
    input  logic [imsu_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [imsu_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import imsu_pkg::*;

    localparam int RW = $clog2(SIDE);
    localparam logic [RW-1:0] LAST_IDX = RW'(SIDE - 1);
    localparam logic signed [MAG_W-1:0]  SPIN_RESET = MAG_W'(SIDE * SIDE);
    localparam logic signed [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SIDE * SIDE);
    localparam logic signed [MAG_W-1:0]  SPIN_STEP  = MAG_W'(2);

    // site reduction table
    logic [RW-1:0] mod_lut [2**SITE_W];
    for (genvar g = 0; g < 2**SITE_W; g++) begin : g_mod
        assign mod_lut[g] = RW'(g % SIDE);
    end

    logic [SITE_W-1:0]    in_row, in_col;
    logic                 in_spin;
    logic [PROB_BITS-1:0] in_draw;
    logic [RW-1:0]        row_in, col_in, up_in;

    assign in_row  = s_tdata[ROW_LSB +: SITE_W];
    assign in_col  = s_tdata[COL_LSB +: SITE_W];
    assign in_spin = s_tdata[SPIN_BIT];
    assign in_draw = s_tdata[DRAW_LSB +: PROB_BITS];
    assign row_in  = mod_lut[in_row];
    assign col_in  = mod_lut[in_col];
    assign up_in   = (row_in == '0) ? LAST_IDX : row_in - 1'b1;

    // item registers
    logic                 op_reg, want_reg;
    logic [RW-1:0]        row_reg, col_reg;
    logic [PROB_BITS-1:0] draw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tuser;
            row_reg  <= row_in;
            col_reg  <= col_in;
            want_reg <= in_spin;
            draw_reg <= in_draw;
        end
    end

    logic [RW-1:0] dn_reg_idx, col_l, col_r;
    assign dn_reg_idx = (row_reg == LAST_IDX) ? '0 : row_reg + 1'b1;
    assign col_l      = (col_reg == '0) ? LAST_IDX : col_reg - 1'b1;
    assign col_r      = (col_reg == LAST_IDX) ? '0 : col_reg + 1'b1;

    // lattice rows, one word per row
    logic [SIDE-1:0] lat_mem [SIDE];
    logic [SIDE-1:0] row_valid_reg;
    logic [SIDE-1:0] rd_a_reg, rd_b_reg, up_row_reg;
    logic            va_reg, vb_reg;
    logic [RW-1:0]   rd_a_addr;
    logic            rd_a_en;
    logic [SIDE-1:0] row_a_word, centre_word, wr_word;
    logic            mem_we;

    assign rd_a_addr = cmd.accept ? up_in : dn_reg_idx;
    assign rd_a_en   = cmd.accept | cmd.read_dn;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lat_mem[row_reg] <= wr_word;
        end
        if (rd_a_en) begin
            rd_a_reg <= lat_mem[rd_a_addr];
        end
        if (cmd.accept) begin
            rd_b_reg <= lat_mem[row_in];
        end
        if (cmd.read_dn) begin
            up_row_reg <= row_a_word;
        end
    end

    // rows never written read as all up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
        end else begin
            if (mem_we) begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            if (rd_a_en) begin
                va_reg <= row_valid_reg[rd_a_addr];
            end
            if (cmd.accept) begin
                vb_reg <= row_valid_reg[row_in];
            end
        end
    end

    assign row_a_word  = va_reg ? rd_a_reg : '1;
    assign centre_word = vb_reg ? rd_b_reg : '1;

    // thresholds
    logic [PROB_BITS-1:0] thr_reg [NUM_THR];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg[REG_ACC_NEG4] <= THR_ONE;
            thr_reg[REG_ACC_NEG2] <= THR_ONE;
            thr_reg[REG_ACC_ZERO] <= THR_ONE;
            thr_reg[REG_ACC_POS2] <= THR_NONE;
            thr_reg[REG_ACC_POS4] <= THR_NONE;
        end else if (cfg_wr_en && (cfg_wr_index <= REG_ACC_POS4)) begin
            thr_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    // acceptance test
    logic                       spin_cur, flip, new_spin;
    logic [2:0]                 n_up;
    logic [CFG_IDX_W-1:0]       sel;
    logic [PROB_BITS-1:0]       thr_sel;
    logic signed [BOND_W-1:0]   bond_delta;
    logic signed [MAG_W-1:0]    spin_total_reg, spin_total_next;
    logic signed [BOND_W-1:0]   bond_total_reg, bond_total_next;

    assign spin_cur = centre_word[col_reg];
    assign n_up     = {2'b00, up_row_reg[col_reg]} + {2'b00, row_a_word[col_reg]}
                    + {2'b00, centre_word[col_l]} + {2'b00, centre_word[col_r]};
    assign sel      = spin_cur ? n_up : 3'd4 - n_up;

    always_comb begin
        unique case (sel)
            REG_ACC_NEG4: begin
                thr_sel    = thr_reg[REG_ACC_NEG4];
                bond_delta = BOND_W'(8);
            end
            REG_ACC_NEG2: begin
                thr_sel    = thr_reg[REG_ACC_NEG2];
                bond_delta = BOND_W'(4);
            end
            REG_ACC_ZERO: begin
                thr_sel    = thr_reg[REG_ACC_ZERO];
                bond_delta = '0;
            end
            REG_ACC_POS2: begin
                thr_sel    = thr_reg[REG_ACC_POS2];
                bond_delta = -BOND_W'(4);
            end
            REG_ACC_POS4: begin
                thr_sel    = thr_reg[REG_ACC_POS4];
                bond_delta = -BOND_W'(8);
            end
            default: begin
                thr_sel    = THR_NONE;
                bond_delta = '0;
            end
        endcase
    end

    assign flip     = (op_reg == OP_TRIAL) ? (draw_reg <= thr_sel) : (want_reg != spin_cur);
    assign new_spin = spin_cur ^ flip;
    assign mem_we   = cmd.exec & flip;

    always_comb begin
        wr_word          = centre_word;
        wr_word[col_reg] = new_spin;
    end

    assign spin_total_next = flip ? spin_total_reg + (spin_cur ? -SPIN_STEP : SPIN_STEP)
                                  : spin_total_reg;
    assign bond_total_next = flip ? bond_total_reg + bond_delta : bond_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spin_total_reg <= SPIN_RESET;
            bond_total_reg <= BOND_RESET;
        end else if (cmd.exec) begin
            spin_total_reg <= spin_total_next;
            bond_total_reg <= bond_total_next;
        end
    end

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.exec) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_tdata_reg <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, bond_total_next,
                            spin_total_next, flip, new_spin};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule
